// ===== rtl/pf_pkg.sv =====
// Shared types and constants for the prime factorizer.
`default_nettype none

package pf_pkg;

   // Default width of the value to factor
   localparam int unsigned DEF_VALUE_BITS = 31;

   // Upper bound on factors emitted for one request
   localparam int unsigned MAX_RESULTS = 30;
   localparam int unsigned COUNT_BITS  = $clog2(MAX_RESULTS);
   localparam logic [COUNT_BITS-1:0] LAST_COUNT = COUNT_BITS'(MAX_RESULTS - 1);

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_TWOS,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EVAL
   } ctrl_state_type;

   // Source of the factor written into the result register
   typedef enum logic [1:0] {
      EMIT_NONE_FOUND,
      EMIT_TWO,
      EMIT_DIVISOR,
      EMIT_REMAIN
   } emit_sel_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic         load;
      logic         shift_two;
      logic         set_three;
      logic         start_div;
      logic         take_quot;
      logic         next_divisor;
      logic         emit;
      logic         emit_last;
      emit_sel_type emit_sel;
   } pf_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic small_value;
      logic rem_even;
      logic two_last;
      logic div_done;
      logic div_exceeds;
      logic div_exact;
      logic quot_one;
      logic count_last;
      logic out_free;
   } pf_status_type;

endpackage

`default_nettype wire

// ===== rtl/pf_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module pf_divider #(
   parameter int unsigned VALUE_BITS = pf_pkg::DEF_VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [VALUE_BITS-1:0] dividend,
   input  wire logic [VALUE_BITS-1:0] divisor,
   output logic                       done,
   output logic [VALUE_BITS-1:0]      quotient,
   output logic [VALUE_BITS-1:0]      remainder
);
   import pf_pkg::*;

   localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
   localparam logic [CNT_W-1:0] ITERS = CNT_W'(VALUE_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      iter_ff, iter_in;
   logic [VALUE_BITS-1:0] part_ff, part_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;

   logic [VALUE_BITS:0]   shifted;
   logic [VALUE_BITS:0]   diff;
   logic                  fits;

   // Trial subtraction of the shifted partial remainder
   assign shifted = {part_ff, quot_ff[VALUE_BITS-1]};
   assign diff    = shifted - {1'b0, divisor};
   assign fits    = !diff[VALUE_BITS];

   // Next-state logic
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      iter_in = iter_ff;
      part_in = part_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         iter_in = ITERS;
         part_in = '0;
         quot_in = dividend;
      end else if (busy_ff) begin
         part_in = fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
         quot_in = {quot_ff[VALUE_BITS-2:0], fits};
         iter_in = iter_ff - CNT_W'(1);
         if (iter_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      part_ff <= part_in;
      quot_ff <= quot_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = part_ff;

endmodule

`default_nettype wire

// ===== rtl/pf_datapath.sv =====
// Datapath: remainder, trial divisor, factor count, divider and result register.
`default_nettype none

module pf_datapath #(
   parameter int unsigned VALUE_BITS = pf_pkg::DEF_VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [VALUE_BITS-1:0] req_value,
   input  wire pf_pkg::pf_cmd_type    cmd,
   output pf_pkg::pf_status_type      status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [VALUE_BITS-1:0]      rsp_factor,
   output logic                       rsp_none_found,
   output logic                       rsp_last
);
   import pf_pkg::*;

   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] div_ff, div_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] factor_ff, factor_in;
   logic                  none_ff, none_in;
   logic                  last_ff, last_in;

   logic                  div_done;
   logic [VALUE_BITS-1:0] quot;
   logic [VALUE_BITS-1:0] remd;
   logic [VALUE_BITS-1:0] emit_value;

   pf_divider #(
      .VALUE_BITS(VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_div),
      .dividend  (rem_ff),
      .divisor   (div_ff),
      .done      (div_done),
      .quotient  (quot),
      .remainder (remd)
   );

   // Factor source select
   always_comb begin
      case (cmd.emit_sel)
         EMIT_NONE_FOUND: emit_value = '0;
         EMIT_TWO:        emit_value = VALUE_BITS'(2);
         EMIT_DIVISOR:    emit_value = div_ff;
         EMIT_REMAIN:     emit_value = rem_ff;
         default:         emit_value = '0;
      endcase
   end

   // Working registers
   always_comb begin
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      if (cmd.load) begin
         rem_in   = req_value;
         count_in = '0;
      end else begin
         if (cmd.shift_two) rem_in = rem_ff >> 1;
         if (cmd.take_quot) rem_in = quot;
         if (cmd.emit)      count_in = count_ff + COUNT_BITS'(1);
      end
      if (cmd.set_three)    div_in = VALUE_BITS'(3);
      if (cmd.next_divisor) div_in = div_ff + VALUE_BITS'(2);
   end

   // Result register: loaded on emit, cleared when taken
   always_comb begin
      valid_in  = valid_ff;
      factor_in = factor_ff;
      none_in   = none_ff;
      last_in   = last_ff;
      if (cmd.emit) begin
         valid_in  = 1'b1;
         factor_in = emit_value;
         none_in   = (cmd.emit_sel == EMIT_NONE_FOUND);
         last_in   = cmd.emit_last;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      factor_ff <= factor_in;
      none_ff   <= none_in;
      last_ff   <= last_in;
   end

   // Status toward the controller
   always_comb begin
      status.small_value = (rem_ff[VALUE_BITS-1:1] == '0);
      status.rem_even    = !rem_ff[0];
      status.two_last    = ((rem_ff >> 1) == VALUE_BITS'(1));
      status.div_done    = div_done;
      status.div_exceeds = (div_ff > quot);
      status.div_exact   = (remd == '0);
      status.quot_one    = (quot == VALUE_BITS'(1));
      status.count_last  = (count_ff == LAST_COUNT);
      status.out_free    = !valid_ff || !rsp_stall;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_factor     = factor_ff;
   assign rsp_none_found = none_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

// ===== rtl/pf_ctrl.sv =====
// Controller state machine sequencing the trial division.
`default_nettype none

module pf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output pf_pkg::pf_cmd_type         cmd,
   input  wire pf_pkg::pf_status_type status
);
   import pf_pkg::*;

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // zero and one have no factors
            if (status.small_value) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_sel  = EMIT_NONE_FOUND;
                  cmd.emit_last = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_TWOS;
            end
         end
         ST_TWOS: begin
            // strip factors of two by shifting
            if (status.rem_even) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_sel  = EMIT_TWO;
                  cmd.emit_last = status.two_last || status.count_last;
                  cmd.shift_two = 1'b1;
                  if (cmd.emit_last) state_in = ST_IDLE;
               end
            end else begin
               cmd.set_three = 1'b1;
               state_in      = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            cmd.start_div = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.div_exceeds) begin
               // divisor past the square root: remainder is prime
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_sel  = EMIT_REMAIN;
                  cmd.emit_last = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (status.div_exact) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_sel  = EMIT_DIVISOR;
                  cmd.emit_last = status.quot_one || status.count_last;
                  cmd.take_quot = 1'b1;
                  state_in      = cmd.emit_last ? ST_IDLE : ST_DIV_START;
               end
            end else begin
               cmd.next_divisor = 1'b1;
               state_in         = ST_DIV_START;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/prime_factorizer_unit.sv =====
// Top level of the trial-division prime factorizer.
//
// Request channel: req_valid / req_stall / req_value. A request is taken when
// req_valid is high and req_stall low; req_stall is high from acceptance until
// the last factor of that request has been written into the result register.
// Result channel: rsp_valid / rsp_stall with rsp_factor, rsp_none_found and
// rsp_last. Factors come out in ascending order with multiplicity; the final
// one carries rsp_last. Inputs 0 and 1 give one result with rsp_none_found set.
// Factors of two are stripped by shifting, without the divider. Each trial with
// an odd divisor costs one pass of the bit-serial divider; the divider sets the
// rate. Trials stop once the divisor exceeds the square root of the remaining
// value, so a large 31-bit prime takes about 23200 trials. One request is
// worked on at a time.
// A stalled result holds the datapath: the next factor waits until the result
// register is free. Reset is synchronous; it returns the controller to idle
// and drops rsp_valid. There is no clearing pass.
`default_nettype none

module prime_factorizer_unit #(
   parameter int unsigned VALUE_BITS = pf_pkg::DEF_VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [VALUE_BITS-1:0]      rsp_factor,
   output logic                       rsp_none_found,
   output logic                       rsp_last
);
   import pf_pkg::*;

   pf_cmd_type    cmd;
   pf_status_type status;

   pf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   pf_datapath #(
      .VALUE_BITS(VALUE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_factor     (rsp_factor),
      .rsp_none_found (rsp_none_found),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/pf_checker.sv =====
// Port-level checker for the prime factorizer, bound to the top level.
`default_nettype none

module pf_checker #(
   parameter int unsigned VALUE_BITS = pf_pkg::DEF_VALUE_BITS
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [VALUE_BITS-1:0] rsp_factor,
   input wire logic                  rsp_none_found,
   input wire logic                  rsp_last
);
   import pf_pkg::*;

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_factor)
         && $stable(rsp_none_found) && $stable(rsp_last))
      else $error("stalled result changed");

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An accepted request blocks further requests in the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // A no-factor result is a lone, final, zero result
   a_none_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_found |-> rsp_last && (rsp_factor == '0))
      else $error("malformed no-factor result");

   // Every real factor is at least two
   a_factor_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_none_found |-> (rsp_factor[VALUE_BITS-1:1] != '0))
      else $error("factor below two");

endmodule

bind prime_factorizer_unit pf_checker #(
   .VALUE_BITS(VALUE_BITS)
) u_pf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_factor     (rsp_factor),
   .rsp_none_found (rsp_none_found),
   .rsp_last       (rsp_last)
);

`default_nettype wire

// ===== sim/prime_factorizer_checker.sv =====
// Scoreboard for the prime factorizer: predicts factors per request and checks results.
`timescale 1ns / 100ps

module prime_factorizer_checker #(
   parameter int unsigned VALUE_BITS = pf_pkg::DEF_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [VALUE_BITS-1:0] rsp_factor,
   input  logic                  rsp_none_found,
   input  logic                  rsp_last,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [VALUE_BITS-1:0] factor;
      logic                  none_found;
      logic                  last;
   } factor_result_type;

   // Factors still owed by the block, oldest first
   factor_result_type expected_factors[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Trial division: twos first, then odd divisors up to the square root of what is left
   function automatic void predict_factors(input logic [VALUE_BITS-1:0] value);
      longint unsigned   rest;
      longint unsigned   divisor;
      int unsigned       count;
      factor_result_type run[$];
      rest    = value;
      divisor = 3;
      count   = 0;
      if (rest < 2) begin
         run.push_back('{factor: '0, none_found: 1'b1, last: 1'b0});
      end else begin
         while (count < pf_pkg::MAX_RESULTS && (rest & 1) == 0) begin
            run.push_back('{factor: VALUE_BITS'(2), none_found: 1'b0, last: 1'b0});
            count++;
            rest = rest >> 1;
         end
         while (count < pf_pkg::MAX_RESULTS && rest > 1 && divisor <= rest / divisor) begin
            while (count < pf_pkg::MAX_RESULTS && rest % divisor == 0) begin
               run.push_back('{factor: VALUE_BITS'(divisor), none_found: 1'b0, last: 1'b0});
               count++;
               rest = rest / divisor;
            end
            divisor += 2;
         end
         // what is left over is a prime larger than every trial divisor
         if (count < pf_pkg::MAX_RESULTS && rest > 1)
            run.push_back('{factor: VALUE_BITS'(rest), none_found: 1'b0, last: 1'b0});
      end
      run[run.size()-1].last = 1'b1;
      foreach (run[i]) expected_factors.push_back(run[i]);
   endfunction

   task automatic log_error(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
   endtask

   // Compare results before predicting, so a result never matches a request of the same edge
   always @(posedge clock) begin : watch
      factor_result_type want;
      factor_result_type got;
      got = '{factor: rsp_factor, none_found: rsp_none_found, last: rsp_last};
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_factors.size() == 0) begin
               log_error($sformatf("unexpected result: factor %0d none_found %0b last %0b",
                                   got.factor, got.none_found, got.last));
            end else begin
               want = expected_factors.pop_front();
               if (got.factor != want.factor || got.none_found != want.none_found ||
                   got.last != want.last)
                  log_error($sformatf({"result mismatch: expected factor %0d none_found %0b ",
                                       "last %0b, got factor %0d none_found %0b last %0b"},
                                      want.factor, want.none_found, want.last,
                                      got.factor, got.none_found, got.last));
            end
         end
         if (req_valid && !req_stall) predict_factors(req_value);
      end
      pending_count = expected_factors.size();
   end

endmodule

// ===== sim/prime_factorizer_unit_tb.sv =====
// Testbench top for the prime factorizer: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module prime_factorizer_unit_tb;

   localparam int unsigned VALUE_BITS  = pf_pkg::DEF_VALUE_BITS;
   localparam int unsigned CYCLE_LIMIT = 5_000_000;
   localparam int unsigned IDLE_PCT    = 27;
   localparam int unsigned RANDOM_REQS = 100;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_stall = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic [VALUE_BITS-1:0] rsp_factor;
   logic                  rsp_none_found;
   logic                  rsp_last;

   int          fail_count;
   int          pending_count;
   int unsigned cycle_count = 0;
   logic        idle_enable = 1'b1;

   // Corners: no factors, small primes, squares, all twos, many threes, bit patterns,
   // and the largest value, which is prime and the slowest case
   logic [VALUE_BITS-1:0] corner_values [18] = '{
      31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd8, 31'd9, 31'd15, 31'd49,
      31'd60491, 31'd65521, 31'd1073741824, 31'd1162261467, 31'd2147483646,
      31'd1431655765, 31'd2147483647
   };

   always #10 clock = ~clock;

   prime_factorizer_unit #(.VALUE_BITS(VALUE_BITS)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_factor     (rsp_factor),
      .rsp_none_found (rsp_none_found),
      .rsp_last       (rsp_last)
   );

   prime_factorizer_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_factor     (rsp_factor),
      .rsp_none_found (rsp_none_found),
      .rsp_last       (rsp_last),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   // Result side back-pressure
   always @(posedge clock) begin
      rsp_stall <= idle_enable && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Mostly products of small factors so the divider finishes quickly; some noise
   function automatic logic [VALUE_BITS-1:0] random_value();
      longint unsigned prod;
      longint unsigned cap;
      longint unsigned mult;
      int unsigned     kind;
      int unsigned     width;
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         width = $urandom_range(1, 16);
         return VALUE_BITS'($urandom & ((32'd1 << width) - 1));
      end
      if (kind < 25) return VALUE_BITS'($urandom_range(0, 127));
      cap  = 64'd1 << $urandom_range(2, VALUE_BITS);
      prod = 1;
      // one larger seed, possibly prime, on top of the small factors
      if (kind >= 75) prod = $urandom_range(2, 65535);
      for (int i = 0; i < 40; i++) begin
         mult = $urandom_range(2, 48);
         if (prod * mult < cap) prod = prod * mult;
      end
      return VALUE_BITS'(prod);
   endfunction

   // Present one request and hold it until taken; valid stays high across back-to-back requests
   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      while (idle_enable && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop sending until every owed factor has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (corner_values[i]) send_value(corner_values[i]);
      drain_results();
      for (int n = 0; n < RANDOM_REQS; n++) begin
         // a stretch with no gaps on either side
         idle_enable = !(n >= 35 && n < 65);
         if (n == 70) drain_results();
         send_value(random_value());
      end
      idle_enable = 1'b1;
      drain_results();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
